// ===== hdl/sha1e_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sha1e_pkg
// Shared types, constants and round functions of the SHA-1 hash engine.
// ----------------------------------------------------------------------------
package sha1e_pkg;

  localparam int WordW = 32;

  localparam logic [7:0] PadByte  = 8'h80;
  localparam logic [7:0] ZeroByte = 8'h00;

  localparam logic [5:0] PosLast = 6'd63;
  localparam logic [5:0] PosLen  = 6'd56;

  localparam logic [6:0] RoundLast = 7'd79;
  localparam logic [6:0] Round20   = 7'd20;
  localparam logic [6:0] Round40   = 7'd40;
  localparam logic [6:0] Round60   = 7'd60;

  localparam logic [2:0] WordLast = 3'd4;

  typedef enum logic [1:0] {
    PH_CH     = 2'd0,
    PH_PAR0   = 2'd1,
    PH_MAJ    = 2'd2,
    PH_PAR1   = 2'd3
  } phase_e;

  localparam logic [WordW-1:0] RoundK [4] = '{
    32'h5a827999, 32'h6ed9eba1, 32'h8f1bbcdc, 32'hca62c1d6
  };

  localparam logic [WordW-1:0] HInit [5] = '{
    32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
  };

  // Command word from the controller to the datapath
  typedef struct packed {
    logic       put_en;
    logic [7:0] put_data;
    logic       cnt_inc;
    logic       len_wr;
    logic       vars_load;
    logic       round_en;
    logic       h_add;
    logic       rearm;
    logic [2:0] word_sel;
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic pos_last;
    logic pos_len;
    logic round_last;
  } sts_t;

  function automatic logic [WordW-1:0] rotl1(input logic [WordW-1:0] v);
    rotl1 = {v[WordW-2:0], v[WordW-1]};
  endfunction

  function automatic logic [WordW-1:0] round_f(input phase_e ph,
                                               input logic [WordW-1:0] b,
                                               input logic [WordW-1:0] c,
                                               input logic [WordW-1:0] d);
    unique case (ph)
      PH_CH:   round_f = (b & c) | (~b & d);
      PH_MAJ:  round_f = (b & c) | (b & d) | (c & d);
      default: round_f = b ^ c ^ d;
    endcase
  endfunction

endpackage : sha1e_pkg
`default_nettype wire

// ===== hdl/sha1e_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sha1e_if
// Valid/ready channels of the SHA-1 hash engine: byte input and digest output.
// ----------------------------------------------------------------------------
interface sha1e_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;
  logic       no_data;

  modport source (output valid, output data_byte, output last_byte, output no_data,
                  input ready);
  modport sink   (input valid, input data_byte, input last_byte, input no_data,
                  output ready);
endinterface : sha1e_in_if

interface sha1e_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  modport source (output valid, output digest_word, output word_index, output last_word,
                  input ready);
  modport sink   (input valid, input digest_word, input word_index, input last_word,
                  output ready);
endinterface : sha1e_out_if
`default_nettype wire

// ===== hdl/sha1e_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sha1e_dp
// Datapath: schedule shift line, byte packing, round unit, chaining words
// and message length counter.
// ----------------------------------------------------------------------------
module sha1e_dp #(
  parameter int LENGTH_BITS = 64
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire sha1e_pkg::cmd_t    cmd_i,
  output sha1e_pkg::sts_t         sts_o,
  output logic [31:0]             digest_o
);
  import sha1e_pkg::*;

  logic [WordW-1:0]       ring_q [16];
  logic [WordW-1:0]       h_q [5];
  logic [WordW-1:0]       v_q [5];
  logic [LENGTH_BITS-1:0] cnt_q;
  logic [5:0]             pos_q;
  logic [6:0]             rnd_q;

  logic [3:0]       wr_idx;
  logic [1:0]       lane;
  logic [4:0]       sh;
  logic [WordW-1:0] byte_word;
  logic [63:0]      len64;
  logic [WordW-1:0] w_new;
  logic [WordW-1:0] f_val;
  logic [WordW-1:0] t_val;
  phase_e           phase;

  assign wr_idx    = pos_q[5:2];
  assign lane      = pos_q[1:0];
  assign sh        = {~lane, 3'b000};
  assign byte_word = WordW'(cmd_i.put_data) << sh;
  assign len64     = 64'(cnt_q);
  assign w_new     = rotl1(ring_q[13] ^ ring_q[8] ^ ring_q[2] ^ ring_q[0]);

  always_comb begin
    priority if (rnd_q < Round20) begin
      phase = PH_CH;
    end else if (rnd_q < Round40) begin
      phase = PH_PAR0;
    end else if (rnd_q < Round60) begin
      phase = PH_MAJ;
    end else begin
      phase = PH_PAR1;
    end
  end

  assign f_val = round_f(phase, v_q[1], v_q[2], v_q[3]);
  assign t_val = {v_q[0][26:0], v_q[0][31:27]} + f_val + v_q[4] + ring_q[0]
               + RoundK[phase];

  // Schedule window: ring_q[0] holds the word of the current round
  always_ff @(posedge clk_i) begin
    if (cmd_i.round_en) begin
      for (int i = 0; i < 15; i++) begin
        ring_q[i] <= ring_q[i+1];
      end
      ring_q[15] <= w_new;
    end else if (cmd_i.len_wr) begin
      ring_q[14] <= len64[63:32];
      ring_q[15] <= len64[31:0];
    end else if (cmd_i.put_en) begin
      if (lane == 2'd0) begin
        ring_q[wr_idx] <= byte_word;
      end else begin
        ring_q[wr_idx] <= ring_q[wr_idx] | byte_word;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h_q   <= HInit;
      v_q   <= '{default: '0};
      cnt_q <= '0;
      pos_q <= '0;
      rnd_q <= '0;
    end else begin
      if (cmd_i.rearm) begin
        h_q <= HInit;
      end else if (cmd_i.h_add) begin
        for (int i = 0; i < 5; i++) begin
          h_q[i] <= h_q[i] + v_q[i];
        end
      end

      if (cmd_i.vars_load) begin
        v_q   <= h_q;
        rnd_q <= '0;
      end else if (cmd_i.round_en) begin
        v_q[4] <= v_q[3];
        v_q[3] <= v_q[2];
        v_q[2] <= {v_q[1][1:0], v_q[1][31:2]};
        v_q[1] <= v_q[0];
        v_q[0] <= t_val;
        rnd_q  <= rnd_q + 7'd1;
      end

      if (cmd_i.rearm) begin
        cnt_q <= '0;
      end else if (cmd_i.cnt_inc) begin
        cnt_q <= cnt_q + LENGTH_BITS'(8);
      end

      if (cmd_i.rearm || cmd_i.len_wr) begin
        pos_q <= '0;
      end else if (cmd_i.put_en) begin
        pos_q <= pos_q + 6'd1;
      end
    end
  end

  assign sts_o.pos_last   = (pos_q == PosLast);
  assign sts_o.pos_len    = (pos_q == PosLen);
  assign sts_o.round_last = (rnd_q == RoundLast);
  assign digest_o         = h_q[cmd_i.word_sel];

endmodule : sha1e_dp
`default_nettype wire

// ===== hdl/sha1e_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sha1e_ctrl
// Controller: byte intake, padding sequence, block compression and digest
// word output.
// ----------------------------------------------------------------------------
module sha1e_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire logic [7:0]      in_data_i,
  input  wire logic            in_last_i,
  input  wire logic            in_none_i,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output logic [2:0]           out_index_o,
  output logic                 out_last_o,
  output sha1e_pkg::cmd_t      cmd_o,
  input  wire sha1e_pkg::sts_t sts_i
);
  import sha1e_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_PAD80 = 7'b0000010,
    S_PADZ  = 7'b0000100,
    S_LOADV = 7'b0001000,
    S_ROUND = 7'b0010000,
    S_ADD   = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_e;

  state_e     state_q, state_d;
  state_e     ret_q, ret_d;
  logic [2:0] idx_q, idx_d;

  always_comb begin
    state_d     = state_q;
    ret_d       = ret_q;
    idx_d       = idx_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    cmd_o.word_sel = idx_q;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (!in_none_i) begin
            cmd_o.put_en   = 1'b1;
            cmd_o.put_data = in_data_i;
            cmd_o.cnt_inc  = 1'b1;
          end
          if (!in_none_i && sts_i.pos_last) begin
            state_d = S_LOADV;
            ret_d   = in_last_i ? S_PAD80 : S_IDLE;
          end else if (in_last_i) begin
            state_d = S_PAD80;
          end
        end
      end
      S_PAD80: begin
        cmd_o.put_en   = 1'b1;
        cmd_o.put_data = PadByte;
        if (sts_i.pos_last) begin
          state_d = S_LOADV;
          ret_d   = S_PADZ;
        end else begin
          state_d = S_PADZ;
        end
      end
      S_PADZ: begin
        if (sts_i.pos_len) begin
          cmd_o.len_wr = 1'b1;
          state_d      = S_LOADV;
          ret_d        = S_OUT;
        end else begin
          cmd_o.put_en   = 1'b1;
          cmd_o.put_data = ZeroByte;
          if (sts_i.pos_last) begin
            state_d = S_LOADV;
            ret_d   = S_PADZ;
          end
        end
      end
      S_LOADV: begin
        cmd_o.vars_load = 1'b1;
        state_d         = S_ROUND;
      end
      S_ROUND: begin
        cmd_o.round_en = 1'b1;
        if (sts_i.round_last) begin
          state_d = S_ADD;
        end
      end
      S_ADD: begin
        cmd_o.h_add = 1'b1;
        state_d     = ret_q;
      end
      S_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          if (idx_q == WordLast) begin
            // final word taken: rearm for the next message
            cmd_o.rearm = 1'b1;
            idx_d       = '0;
            state_d     = S_IDLE;
          end else begin
            idx_d = idx_q + 3'd1;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ret_q   <= S_IDLE;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      idx_q   <= idx_d;
    end
  end

  assign out_index_o = idx_q;
  assign out_last_o  = (idx_q == WordLast);

endmodule : sha1e_ctrl
`default_nettype wire

// ===== hdl/sha1_hash_engine_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sha1_hash_engine_core
// SHA-1 digest of a byte message, one byte per input word, five digest words
// out at message end.
// ----------------------------------------------------------------------------
// A byte word is taken while the engine is idle; the word that fills a 64-byte block
// starts the compression (load, 80 rounds on one round unit, add), during which no byte is taken.
// Message end: the 0x80 byte, the zero pad bytes (up to 63), the length write and
// one or two padded blocks, then five output words.
// Reset is asynchronous: chaining words to the initial values, length and position
// cleared; the schedule line is not cleared and is always refilled.
module sha1_hash_engine_core #(
  parameter int LENGTH_BITS = 64
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  sha1e_in_if.sink    in_if,
  sha1e_out_if.source out_if
);
  import sha1e_pkg::*;

  cmd_t cmd;
  sts_t sts;

  sha1e_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_if.valid),
    .in_ready_o  (in_if.ready),
    .in_data_i   (in_if.data_byte),
    .in_last_i   (in_if.last_byte),
    .in_none_i   (in_if.no_data),
    .out_valid_o (out_if.valid),
    .out_ready_i (out_if.ready),
    .out_index_o (out_if.word_index),
    .out_last_o  (out_if.last_word),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  sha1e_dp #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .sts_o    (sts),
    .digest_o (out_if.digest_word)
  );

  // digest words and byte intake never overlap
  a_out_blocks_in : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid |-> !in_if.ready)
    else $error("input ready while digest pending");

  a_last_is_four : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_if.valid && out_if.last_word) |-> (out_if.word_index == WordLast))
    else $error("last word flag on wrong index");

  a_rearm_ready : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_if.valid && out_if.ready && out_if.last_word) |=> in_if.ready)
    else $error("not ready after final digest word");

  a_empty_item : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_if.valid && in_if.ready && in_if.no_data && !in_if.last_byte) |=> in_if.ready)
    else $error("empty item stalled the engine");

endmodule : sha1_hash_engine_core
`default_nettype wire

// ===== tb/tb_sha1_hash_engine_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sha1_hash_engine_core
// Feeds byte messages into the SHA-1 engine and checks every digest word
// against a behavioral SHA-1 in the bench or a known digest. A short table of
// directed words comes first, then random messages with lengths clustered
// around the padding and block boundaries, under four handshake idle settings.
// ----------------------------------------------------------------------------
module tb_sha1_hash_engine_core;

  typedef enum logic [1:0] {
    KNOWN_NONE  = 2'd0,
    KNOWN_EMPTY = 2'd1,
    KNOWN_ABC   = 2'd2
  } known_e;

  typedef enum logic [1:0] {
    IDLE_NONE = 2'd0,
    IDLE_SRC  = 2'd1,
    IDLE_SNK  = 2'd2,
    IDLE_BOTH = 2'd3
  } idle_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
    logic       no_data;
    known_e     known;
  } stim_row_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } digest_exp_t;

  localparam int RandItems  = 400;
  localparam int DrainCycles = 300;

  localparam logic [31:0] RoundAdd [4] = '{
    32'h5a827999, 32'h6ed9eba1, 32'h8f1bbcdc, 32'hca62c1d6
  };
  localparam logic [31:0] ChainInit [5] = '{
    32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
  };
  localparam logic [7:0] PadMark = 8'h80;

  localparam logic [31:0] EmptyDigest [5] = '{
    32'hda39a3ee, 32'h5e6b4b0d, 32'h3255bfef, 32'h95601890, 32'hafd80709
  };
  localparam logic [31:0] AbcDigest [5] = '{
    32'ha9993e36, 32'h4706816a, 32'hba3e2571, 32'h7850c26c, 32'h9cd0d89d
  };

  localparam int DirCount = 16;
  localparam stim_row_t DirRows [DirCount] = '{
    '{8'ha5, 1'b0, 1'b1, KNOWN_NONE},   // empty word right after reset
    '{8'h00, 1'b1, 1'b1, KNOWN_EMPTY},  // empty message
    '{8'h61, 1'b0, 1'b0, KNOWN_NONE},
    '{8'h62, 1'b0, 1'b0, KNOWN_NONE},
    '{8'h63, 1'b1, 1'b0, KNOWN_ABC},    // end flagged on a data byte
    '{8'hff, 1'b1, 1'b0, KNOWN_NONE},
    '{8'h00, 1'b1, 1'b1, KNOWN_EMPTY},  // empty message after a finished one
    '{8'h00, 1'b1, 1'b0, KNOWN_NONE},
    '{8'hff, 1'b0, 1'b0, KNOWN_NONE},
    '{8'h5a, 1'b0, 1'b1, KNOWN_NONE},   // empty word inside a message
    '{8'h00, 1'b0, 1'b0, KNOWN_NONE},
    '{8'hc3, 1'b1, 1'b1, KNOWN_NONE},   // end without a byte
    '{8'h80, 1'b0, 1'b0, KNOWN_NONE},
    '{8'h7f, 1'b0, 1'b0, KNOWN_NONE},
    '{8'h01, 1'b1, 1'b0, KNOWN_NONE},
    '{8'hfe, 1'b1, 1'b1, KNOWN_EMPTY}   // data bits ignored on an end-only word
  };

  localparam int BoundCount = 10;
  localparam int BoundLens [BoundCount] = '{54, 55, 56, 57, 63, 64, 65, 119, 120, 128};

  logic clk_i;
  logic rst_ni;

  sha1e_in_if  in_ch ();
  sha1e_out_if out_ch ();

  sha1_hash_engine_core uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  // Behavioral SHA-1 state
  logic [7:0]  msg_blk [64];
  int unsigned blk_fill;
  logic [63:0] msg_bits;
  logic [31:0] chain_h [5];

  digest_exp_t digest_q [$];

  int unsigned src_idle_pct;
  int unsigned snk_stall_pct;
  int unsigned fail_count;
  int unsigned words_checked;
  int unsigned msgs_sent;
  int unsigned bytes_sent;
  int unsigned empties_sent;

  initial begin
    clk_i = 1'b0;
  end

  always #5 clk_i = ~clk_i;

  function automatic void rearm_digest();
    for (int i = 0; i < 5; i++) chain_h[i] = ChainInit[i];
    blk_fill = 0;
    msg_bits = '0;
  endfunction

  function automatic void fold_block();
    logic [31:0] w [80];
    logic [31:0] a, b, c, d, e, f, x, t;
    for (int i = 0; i < 16; i++)
      w[i] = {msg_blk[4*i], msg_blk[4*i+1], msg_blk[4*i+2], msg_blk[4*i+3]};
    for (int i = 16; i < 80; i++) begin
      x = w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16];
      w[i] = {x[30:0], x[31]};
    end
    a = chain_h[0];
    b = chain_h[1];
    c = chain_h[2];
    d = chain_h[3];
    e = chain_h[4];
    for (int i = 0; i < 80; i++) begin
      if (i < 20) f = (b & c) | (~b & d);
      else if (i >= 40 && i < 60) f = (b & c) | (b & d) | (c & d);
      else f = b ^ c ^ d;
      t = {a[26:0], a[31:27]} + f + e + w[i] + RoundAdd[i / 20];
      e = d;
      d = c;
      c = {b[1:0], b[31:2]};
      b = a;
      a = t;
    end
    chain_h[0] += a;
    chain_h[1] += b;
    chain_h[2] += c;
    chain_h[3] += d;
    chain_h[4] += e;
  endfunction

  function automatic void append_byte(input logic [7:0] v);
    msg_blk[blk_fill] = v;
    blk_fill++;
    if (blk_fill == 64) begin
      fold_block();
      blk_fill = 0;
    end
  endfunction

  // Advance the digest by one input word; return 1 with the digest at message end.
  function automatic bit take_item(input logic [7:0] d, input logic l, input logic n,
                                   output logic [31:0] dig [5]);
    logic [63:0] len;
    if (!n) begin
      msg_bits += 64'd8;
      append_byte(d);
    end
    if (!l) return 1'b0;
    len = msg_bits;
    append_byte(PadMark);
    while (blk_fill != 56) append_byte(8'h00);
    for (int i = 7; i >= 0; i--) append_byte(len[8*i +: 8]);
    for (int i = 0; i < 5; i++) dig[i] = chain_h[i];
    rearm_digest();
    return 1'b1;
  endfunction

  task automatic send_word(input logic [7:0] d, input logic l, input logic n,
                           input known_e kn);
    logic [31:0] dig [5];
    logic [31:0] want;
    @(negedge clk_i);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid     <= 1'b1;
    in_ch.data_byte <= d;
    in_ch.last_byte <= l;
    in_ch.no_data   <= n;
    do @(posedge clk_i); while (in_ch.ready !== 1'b1);
    if (n) empties_sent++;
    else bytes_sent++;
    if (take_item(d, l, n, dig)) begin
      msgs_sent++;
      for (int i = 0; i < 5; i++) begin
        case (kn)
          KNOWN_EMPTY: want = EmptyDigest[i];
          KNOWN_ABC:   want = AbcDigest[i];
          default:     want = dig[i];
        endcase
        digest_q.push_back('{want, 3'(i), (i == 4)});
      end
    end
  endtask

  task automatic set_idle(input idle_e mode);
    src_idle_pct  = (mode == IDLE_SRC) ? 48 : (mode == IDLE_BOTH) ? 22 : 0;
    snk_stall_pct = (mode == IDLE_SNK) ? 48 : (mode == IDLE_BOTH) ? 22 : 0;
  endtask

  // Hold the sender until the engine has handed out everything owed.
  task automatic hold_until_drained();
    while (digest_q.size() != 0) @(posedge clk_i);
  endtask

  // Digest word checker
  always @(posedge clk_i) begin
    digest_exp_t exp_w;
    if (rst_ni && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (digest_q.size() == 0) begin
        $error("unexpected digest word %h (index %0d)", out_ch.digest_word,
               out_ch.word_index);
        fail_count++;
      end else begin
        exp_w = digest_q.pop_front();
        words_checked++;
        if (out_ch.digest_word !== exp_w.digest_word) begin
          $error("digest_word: expected %h, got %h", exp_w.digest_word,
                 out_ch.digest_word);
          fail_count++;
        end
        if (out_ch.word_index !== exp_w.word_index) begin
          $error("word_index: expected %0d, got %0d", exp_w.word_index,
                 out_ch.word_index);
          fail_count++;
        end
        if (out_ch.last_word !== exp_w.last_word) begin
          $error("last_word: expected %0b, got %0b", exp_w.last_word,
                 out_ch.last_word);
          fail_count++;
        end
      end
    end
  end

  // Output backpressure
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      out_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  initial begin
    #5_000_000;
    $display("tb_sha1_hash_engine_core NOT OK");
    $finish;
  end

  initial begin
    int unsigned rand_words;
    int unsigned len;
    int unsigned sel;
    int unsigned phase;
    int unsigned cur_phase;
    bit end_on_byte;
    rst_ni          = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.data_byte = 8'h00;
    in_ch.last_byte = 1'b0;
    in_ch.no_data   = 1'b0;
    fail_count      = 0;
    words_checked   = 0;
    msgs_sent       = 0;
    bytes_sent      = 0;
    empties_sent    = 0;
    rand_words      = 0;
    cur_phase       = 0;
    set_idle(IDLE_NONE);
    rearm_digest();
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < DirCount; i++)
      send_word(DirRows[i].data_byte, DirRows[i].last_byte, DirRows[i].no_data,
                DirRows[i].known);

    while (rand_words < RandItems) begin
      phase = (rand_words * 4) / RandItems;
      if (phase != cur_phase) begin
        cur_phase = phase;
        @(negedge clk_i);
        in_ch.valid <= 1'b0;
        hold_until_drained();
        set_idle(idle_e'(phase));
      end
      sel = $urandom_range(9);
      if (sel < 5) len = $urandom_range(8);
      else if (sel < 8) len = BoundLens[$urandom_range(BoundCount - 1)];
      else len = $urandom_range(130);
      end_on_byte = (len != 0) && $urandom_range(1);
      for (int unsigned i = 0; i < len; i++) begin
        // sprinkle empty words as noise
        if ($urandom_range(9) == 0) begin
          send_word(8'($urandom_range(255)), 1'b0, 1'b1, KNOWN_NONE);
          rand_words++;
        end
        send_word(8'($urandom_range(255)), end_on_byte && (i == len - 1), 1'b0,
                  KNOWN_NONE);
        rand_words++;
      end
      if (!end_on_byte) begin
        send_word(8'($urandom_range(255)), 1'b1, 1'b1, KNOWN_NONE);
        rand_words++;
      end
    end

    @(negedge clk_i);
    in_ch.valid <= 1'b0;
    hold_until_drained();
    repeat (DrainCycles) @(posedge clk_i);

    $display("Hashed %0d messages from %0d bytes and %0d end-only or empty words.",
             msgs_sent, bytes_sent, empties_sent);
    $display("Compared %0d digest words under four idle and stall settings.",
             words_checked);
    if (fail_count == 0) begin
      $display("tb_sha1_hash_engine_core OK");
    end else begin
      $display("tb_sha1_hash_engine_core NOT OK");
    end
    $finish;
  end

endmodule : tb_sha1_hash_engine_core
